// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
// needs nothing else; each use names its own clock and active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/erc_pkg.sv =====
// types, rotor tables and small helper functions of the rotor cipher
// used by enigma_rotor_cipher_top; depends on nothing
package erc_pkg;

  typedef logic [4:0] letter_t;

  typedef struct packed {
    logic       op;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    letter_t    pos_slot0;
    letter_t    pos_slot1;
    letter_t    pos_slot2;
  } out_item_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 50;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTOR_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLUG_LOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLUG_HIGH   = 2'd3;

  localparam logic       OP_CHAR = 1'b0;
  localparam logic       OP_LOAD = 1'b1;

  localparam logic [5:0] ROTOR_ORDER_RST = 6'd36;
  localparam letter_t    LAST_LETTER     = 5'd25;
  localparam logic [5:0] ALPHA           = 6'd26;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // rotors I, II, III
  localparam letter_t WIRE_FWD [3][26] = '{
    '{5'd4,  5'd10, 5'd12, 5'd5,  5'd11, 5'd6,  5'd3,  5'd16, 5'd21, 5'd25,
      5'd13, 5'd19, 5'd14, 5'd22, 5'd24, 5'd7,  5'd23, 5'd20, 5'd18, 5'd15,
      5'd0,  5'd8,  5'd1,  5'd17, 5'd2,  5'd9},
    '{5'd0,  5'd9,  5'd3,  5'd10, 5'd18, 5'd8,  5'd17, 5'd20, 5'd23, 5'd1,
      5'd11, 5'd7,  5'd22, 5'd19, 5'd12, 5'd2,  5'd16, 5'd6,  5'd25, 5'd13,
      5'd15, 5'd24, 5'd5,  5'd21, 5'd14, 5'd4},
    '{5'd1,  5'd3,  5'd5,  5'd7,  5'd9,  5'd11, 5'd2,  5'd15, 5'd17, 5'd19,
      5'd23, 5'd21, 5'd25, 5'd13, 5'd24, 5'd4,  5'd8,  5'd22, 5'd6,  5'd0,
      5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14}
  };

  localparam letter_t WIRE_INV [3][26] = '{
    '{5'd20, 5'd22, 5'd24, 5'd6,  5'd0,  5'd3,  5'd5,  5'd15, 5'd21, 5'd25,
      5'd1,  5'd4,  5'd2,  5'd10, 5'd12, 5'd19, 5'd7,  5'd23, 5'd18, 5'd11,
      5'd17, 5'd8,  5'd13, 5'd16, 5'd14, 5'd9},
    '{5'd0,  5'd9,  5'd15, 5'd2,  5'd25, 5'd22, 5'd17, 5'd11, 5'd5,  5'd1,
      5'd3,  5'd10, 5'd14, 5'd19, 5'd24, 5'd20, 5'd16, 5'd6,  5'd4,  5'd13,
      5'd7,  5'd23, 5'd12, 5'd8,  5'd21, 5'd18},
    '{5'd19, 5'd0,  5'd6,  5'd1,  5'd15, 5'd2,  5'd18, 5'd3,  5'd16, 5'd4,
      5'd20, 5'd5,  5'd21, 5'd13, 5'd25, 5'd7,  5'd24, 5'd8,  5'd23, 5'd9,
      5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12}
  };

  localparam letter_t REFLECT [26] = '{
    5'd24, 5'd17, 5'd20, 5'd7,  5'd16, 5'd18, 5'd11, 5'd3,  5'd15, 5'd23,
    5'd10, 5'd6,  5'd14, 5'd13, 5'd12, 5'd8,  5'd4,  5'd1,  5'd5,  5'd25,
    5'd2,  5'd22, 5'd21, 5'd9,  5'd0,  5'd19
  };

  localparam letter_t NOTCH [3] = '{5'd17, 5'd5, 5'd22};

  // selector code 3 means rotor III
  function automatic logic [1:0] slot_rotor(input logic [1:0] code);
    return (code == 2'd3) ? 2'd2 : code;
  endfunction

  function automatic letter_t sat_pos(input letter_t s);
    return (s > LAST_LETTER) ? LAST_LETTER : s;
  endfunction

  function automatic letter_t add_mod(input letter_t a, input letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= ALPHA) begin
      s = s - ALPHA;
    end
    return s[4:0];
  endfunction

  function automatic letter_t sub_mod(input letter_t a, input letter_t b);
    logic [5:0] d;
    if (a >= b) begin
      d = {1'b0, a} - {1'b0, b};
    end else begin
      d = {1'b0, a} + ALPHA - {1'b0, b};
    end
    return d[4:0];
  endfunction

  function automatic letter_t step_pos(input letter_t p);
    return (p == LAST_LETTER) ? 5'd0 : p + 5'd1;
  endfunction

  // later pairs override earlier ones, unused pairs do nothing
  function automatic letter_t plug_map(input letter_t x,
                                       input logic [CFG_DATA_W-1:0] lo,
                                       input logic [CFG_DATA_W-1:0] hi);
    logic [2*CFG_DATA_W-1:0] pairs;
    letter_t a;
    letter_t b;
    letter_t r;
    pairs = {hi, lo};
    r = x;
    for (int k = 0; k < 10; k++) begin
      a = pairs[10*k +: 5];
      b = pairs[10*k+5 +: 5];
      if (a != b && a <= LAST_LETTER && b <= LAST_LETTER) begin
        if (x == a) begin
          r = b;
        end
        if (x == b) begin
          r = a;
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/enigma_rotor_cipher_top.sv =====
// three-rotor cipher: input register, combinational cipher path, result register
// depends on erc_pkg and assert_macros.svh
//
// Takes one item per clock while out_stall is low and returns one result per
// item, registered first in the input and then in the result register. An
// item either loads the start positions (op = 1) or ciphers one ASCII
// character: letters step the rotors and come back upper case, anything else
// passes through. The cycle is set by the lookup chain from the input
// register through plugboard, three rotors, reflector, three inverse rotors
// and plugboard into the result register. Rotor positions are held per rotor,
// so a rotor placed in two slots shares one position. Write configuration
// only while no item is in flight.
module enigma_rotor_cipher_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  erc_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output erc_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  logic [erc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [erc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import erc_pkg::*;

  logic [5:0]            rotor_order_r;
  logic [14:0]           start_pos_r;
  logic [CFG_DATA_W-1:0] plug_low_r;
  logic [CFG_DATA_W-1:0] plug_high_r;

  letter_t   pos_r [3];
  letter_t   pos_nxt [3];

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  logic      out_free;
  logic      s1_go;

  logic      pos_ok;
  logic      out_pos_ok;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // cipher path
  always_comb begin
    logic [1:0] sel [3];
    logic       is_upper;
    logic       is_lower;
    logic [7:0] base;
    letter_t    x;
    logic [7:0] ch;
    logic [7:0] res;

    ch = s1_item_r.char_in;
    for (int i = 0; i < 3; i++) begin
      sel[i] = slot_rotor(rotor_order_r[2*i +: 2]);
      pos_nxt[i] = pos_r[i];
    end
    is_upper = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z);
    is_lower = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z);
    base = is_lower ? CH_LOWER_A : CH_UPPER_A;
    x = 5'(ch - base);
    res = ch;

    if (s1_item_r.op == OP_LOAD) begin
      // higher slot wins when one rotor sits in two slots
      for (int i = 0; i < 3; i++) begin
        pos_nxt[sel[i]] = sat_pos(start_pos_r[5*i +: 5]);
      end
      res = 8'd0;
    end else if (is_upper || is_lower) begin
      x = plug_map(x, plug_low_r, plug_high_r);
      pos_nxt[sel[0]] = step_pos(pos_nxt[sel[0]]);
      if (pos_nxt[sel[0]] == NOTCH[sel[0]]) begin
        pos_nxt[sel[1]] = step_pos(pos_nxt[sel[1]]);
      end
      if (pos_nxt[sel[1]] == NOTCH[sel[1]]) begin
        pos_nxt[sel[2]] = step_pos(pos_nxt[sel[2]]);
      end
      x = WIRE_FWD[sel[0]][add_mod(x, pos_nxt[sel[0]])];
      x = WIRE_FWD[sel[1]][add_mod(x, pos_nxt[sel[1]])];
      x = WIRE_FWD[sel[2]][add_mod(x, pos_nxt[sel[2]])];
      x = REFLECT[x];
      x = sub_mod(WIRE_INV[sel[2]][x], pos_nxt[sel[2]]);
      x = sub_mod(WIRE_INV[sel[1]][x], pos_nxt[sel[1]]);
      x = sub_mod(WIRE_INV[sel[0]][x], pos_nxt[sel[0]]);
      x = plug_map(x, plug_low_r, plug_high_r);
      res = CH_UPPER_A + {3'd0, x};
    end

    out_item_nxt.char_out  = res;
    out_item_nxt.pos_slot0 = pos_nxt[sel[0]];
    out_item_nxt.pos_slot1 = pos_nxt[sel[1]];
    out_item_nxt.pos_slot2 = pos_nxt[sel[2]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotor_order_r <= ROTOR_ORDER_RST;
      start_pos_r   <= '0;
      plug_low_r    <= '0;
      plug_high_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROTOR_ORDER: rotor_order_r <= cfg_data[5:0];
        CFG_START_POS:   start_pos_r   <= cfg_data[14:0];
        CFG_PLUG_LOW:    plug_low_r    <= cfg_data;
        CFG_PLUG_HIGH:   plug_high_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_go) begin
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item_r <= in_item;
    end
    if (s1_go) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign pos_ok = (pos_r[0] <= LAST_LETTER) && (pos_r[1] <= LAST_LETTER) &&
                  (pos_r[2] <= LAST_LETTER);
  assign out_pos_ok = (out_item_r.pos_slot0 <= LAST_LETTER) &&
                      (out_item_r.pos_slot1 <= LAST_LETTER) &&
                      (out_item_r.pos_slot2 <= LAST_LETTER);

`include "assert_macros.svh"

  `ASSERT_IMPL(a_pos_range, clk, rst_n, 1'b1, pos_ok)
  `ASSERT_IMPL(a_out_pos_range, clk, rst_n, out_valid_r, out_pos_ok)
  `ASSERT_NEXT(a_s1_held, clk, rst_n, s1_valid_r && !out_free, s1_valid_r && $stable(s1_item_r))
  `ASSERT_NEXT(a_out_loaded, clk, rst_n, s1_go, out_valid_r)

endmodule
